// ===== rtl/assert_macros.svh =====
// assertion helpers used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/mm4_pkg.sv =====
`default_nettype none

package mm4_pkg;

    // fixed field widths
    localparam int FUNC_W    = 2;
    localparam int IDX_OUT_W = 2;
    localparam int VALUE_W   = 16;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int SUM_W     = 34;

    typedef logic [FUNC_W-1:0]    t_func;
    typedef logic [IDX_OUT_W-1:0] t_idx;

    // request function codes
    localparam t_func FUNC_LOAD_A  = 2'd0;
    localparam t_func FUNC_LOAD_B  = 2'd1;
    localparam t_func FUNC_COMPUTE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH0,
        S_FLUSH1
    } t_state;

    // element write commands
    typedef struct packed {
        logic we_a;
        logic we_b;
    } t_load_cmd;

    // one multiply-accumulate step travelling down the pipeline
    typedef struct packed {
        logic issue;
        logic first;
        logic last_k;
        logic last_elem;
        t_idx row;
        t_idx col;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ===== rtl/mm4_ram.sv =====
`default_nettype none

module mm4_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/mm4_ctrl.sv =====
`default_nettype none

module mm4_ctrl #(
    parameter int DIM = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire mm4_pkg::t_func                    i_func,
    input  wire mm4_pkg::t_idx                     i_row,
    input  wire mm4_pkg::t_idx                     i_col,
    output logic                                   o_busy,
    output mm4_pkg::t_load_cmd                     o_load,
    output logic [$clog2(DIM*DIM)-1:0]             o_load_addr,
    output mm4_pkg::t_mac_ctl                      o_mac,
    output logic [$clog2(DIM*DIM)-1:0]             o_addr_a,
    output logic [$clog2(DIM*DIM)-1:0]             o_addr_b
);

    import mm4_pkg::*;

    localparam int ADDR_W = $clog2(DIM * DIM);
    localparam int IDX_W  = $clog2(DIM);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic             accept;
    logic             last_issue;

    assign accept     = i_start && (r_state == S_IDLE);
    assign last_issue = (r_i == IDX_MAX) && (r_j == IDX_MAX) && (r_k == IDX_MAX);

    // next state and loop counters
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_func == FUNC_COMPUTE)) begin
                    n_state = S_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            S_RUN: begin
                if (r_k == IDX_MAX) begin
                    n_k = '0;
                    if (r_j == IDX_MAX) begin
                        n_j = '0;
                        n_i = r_i + IDX_W'(1);
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
                if (last_issue) begin
                    n_state = S_FLUSH0;
                end
            end
            S_FLUSH0: n_state = S_FLUSH1;
            S_FLUSH1: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_busy            = (r_state != S_IDLE);
        o_load.we_a       = accept && (i_func == FUNC_LOAD_A)
                            && (int'(i_row) < DIM) && (int'(i_col) < DIM);
        o_load.we_b       = accept && (i_func == FUNC_LOAD_B)
                            && (int'(i_row) < DIM) && (int'(i_col) < DIM);
        o_load_addr       = ADDR_W'(i_row) * ADDR_W'(DIM) + ADDR_W'(i_col);
        o_mac.issue       = (r_state == S_RUN);
        o_mac.first       = (r_k == '0);
        o_mac.last_k      = (r_k == IDX_MAX);
        o_mac.last_elem   = last_issue;
        o_mac.row         = IDX_OUT_W'(r_i);
        o_mac.col         = IDX_OUT_W'(r_j);
        o_addr_a          = ADDR_W'(r_i) * ADDR_W'(DIM) + ADDR_W'(r_k);
        o_addr_b          = ADDR_W'(r_k) * ADDR_W'(DIM) + ADDR_W'(r_j);
    end

    // state and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mm4_datapath.sv =====
`default_nettype none

module mm4_datapath #(
    parameter int DIM = 4
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire mm4_pkg::t_load_cmd                    i_load,
    input  wire logic [$clog2(DIM*DIM)-1:0]            i_load_addr,
    input  wire logic signed [mm4_pkg::VALUE_W-1:0]    i_value,
    input  wire mm4_pkg::t_mac_ctl                     i_mac,
    input  wire logic [$clog2(DIM*DIM)-1:0]            i_addr_a,
    input  wire logic [$clog2(DIM*DIM)-1:0]            i_addr_b,
    output logic                                       o_strobe,
    output mm4_pkg::t_idx                              o_out_row,
    output mm4_pkg::t_idx                              o_out_col,
    output logic signed [mm4_pkg::SUM_W-1:0]           o_product,
    output logic                                       o_last
);

    import mm4_pkg::*;

    localparam int DEPTH = DIM * DIM;

    logic [DEPTH-1:0]          r_valid_a;
    logic [DEPTH-1:0]          r_valid_b;
    logic                      r_va;
    logic                      r_vb;
    logic [VALUE_W-1:0]        rd_a;
    logic [VALUE_W-1:0]        rd_b;
    logic signed [VALUE_W-1:0] op_a;
    logic signed [VALUE_W-1:0] op_b;
    t_mac_ctl                  r_s1;
    t_mac_ctl                  r_s2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SUM_W-1:0]   r_acc;
    logic signed [SUM_W-1:0]   n_sum;
    logic                      r_strobe;
    t_idx                      r_out_row;
    t_idx                      r_out_col;
    logic signed [SUM_W-1:0]   r_out_product;
    logic                      r_out_last;

    // element stores
    mm4_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_load.we_a),
        .i_waddr (i_load_addr),
        .i_wdata (i_value),
        .i_raddr (i_addr_a),
        .o_rdata (rd_a)
    );

    mm4_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_load.we_b),
        .i_waddr (i_load_addr),
        .i_wdata (i_value),
        .i_raddr (i_addr_b),
        .o_rdata (rd_b)
    );

    // written flags, an unwritten element reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= '0;
            r_valid_b <= '0;
        end else begin
            if (i_load.we_a) begin
                r_valid_a[i_load_addr] <= 1'b1;
            end
            if (i_load.we_b) begin
                r_valid_b[i_load_addr] <= 1'b1;
            end
        end
    end

    // flag lookup alongside the ram read
    always_ff @(posedge i_clk) begin
        r_va <= r_valid_a[i_addr_a];
        r_vb <= r_valid_b[i_addr_b];
    end

    assign op_a = r_va ? $signed(rd_a) : '0;
    assign op_b = r_vb ? $signed(rd_b) : '0;

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    // accumulate, wrapping at the result width
    assign n_sum = (r_s2.first ? SUM_W'(0) : r_acc)
                   + {{(SUM_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (r_s2.issue) begin
            r_acc <= n_sum;
        end
        if (r_s2.issue && r_s2.last_k) begin
            r_out_row     <= r_s2.row;
            r_out_col     <= r_s2.col;
            r_out_product <= n_sum;
            r_out_last    <= r_s2.last_elem;
        end
    end

    // step control pipeline and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1     <= '0;
            r_s2     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_s1     <= i_mac;
            r_s2     <= r_s1;
            r_strobe <= r_s2.issue && r_s2.last_k;
        end
    end

    assign o_strobe  = r_strobe;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_product = r_out_product;
    assign o_last    = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/matrix_multiply_4x4_top.sv =====
// DIM x DIM signed fixed-point matrix multiplier, C = A * B
// requests: start with i_func, i_row, i_col, i_value; taken at an edge with
// start high and busy low
// load A / load B write one Q8.8 element and give no
// result; out-of-range indices and the unused function code are dropped
// compute runs one multiply-accumulate per cycle on a single multiplier,
// walking k inside j inside i, so a compute request holds busy through
// the S_RUN, S_FLUSH0 and S_FLUSH1 states
// each element of C leaves on o_strobe for exactly one cycle, in row-major
// order; the last one, with o_last, appears in the first cycle that busy
// is low again
// results are Q18.16, summed exactly and kept to 34 bits; the receiver
// cannot hold results off, so none is ever stalled
// synchronous active-low reset clears the controller and marks every
// element of both matrices as zero; it takes effect on the next edge
`default_nettype none

`include "assert_macros.svh"

module matrix_multiply_4x4_top #(
    parameter int DIM = 4
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire mm4_pkg::t_func                        i_func,
    input  wire mm4_pkg::t_idx                         i_row,
    input  wire mm4_pkg::t_idx                         i_col,
    input  wire logic signed [mm4_pkg::VALUE_W-1:0]    i_value,
    output logic                                       o_strobe,
    output mm4_pkg::t_idx                              o_out_row,
    output mm4_pkg::t_idx                              o_out_col,
    output logic signed [mm4_pkg::SUM_W-1:0]           o_product,
    output logic                                       o_last
);

    import mm4_pkg::*;

    localparam int ADDR_W = $clog2(DIM * DIM);

    t_load_cmd         load_cmd;
    t_mac_ctl          mac_ctl;
    logic [ADDR_W-1:0] load_addr;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;

    // sequencer
    mm4_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_func      (i_func),
        .i_row       (i_row),
        .i_col       (i_col),
        .o_busy      (busy),
        .o_load      (load_cmd),
        .o_load_addr (load_addr),
        .o_mac       (mac_ctl),
        .o_addr_a    (addr_a),
        .o_addr_b    (addr_b)
    );

    // stores, multiplier and accumulator
    mm4_datapath #(
        .DIM (DIM)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load_cmd),
        .i_load_addr (load_addr),
        .i_value     (i_value),
        .i_mac       (mac_ctl),
        .i_addr_a    (addr_a),
        .i_addr_b    (addr_b),
        .o_strobe    (o_strobe),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_product   (o_product),
        .o_last      (o_last)
    );

    // a compute request always makes the block busy
    `ASSERT_NEXT(a_compute_busy, i_clk, i_rst_n, start && !busy && (i_func == FUNC_COMPUTE), busy)

    // the flushed pipeline delivers the final element as busy drops
    `ASSERT_SAME(a_last_at_end, i_clk, i_rst_n, $fell(busy), o_strobe && o_last)

    // the final element is the bottom-right corner
    `ASSERT_SAME(a_last_corner, i_clk, i_rst_n, o_strobe && o_last, (o_out_row == IDX_OUT_W'(DIM - 1)) && (o_out_col == IDX_OUT_W'(DIM - 1)))

    // no result while idle except the final one
    `ASSERT_SAME(a_no_idle_result, i_clk, i_rst_n, o_strobe && !o_last, busy)

endmodule

`default_nettype wire
